// ===== hdl/lpht_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the linear probing hash table.
// No dependencies; every other file but lpht_queue takes names from here by scope.
package lpht_pkg;

    localparam int KEY_W              = 32;
    localparam int CFG_W              = 11;
    localparam int COUNT_W            = 11;
    localparam int SLOT_OUT_W         = 10;
    localparam int STATUS_W           = 2;
    localparam int MOD_BITS_PER_CYCLE = 4;
    localparam int MOD_CYCLES         = KEY_W / MOD_BITS_PER_CYCLE;
    localparam int MOD_CNT_W          = $clog2(MOD_CYCLES);

    localparam logic [KEY_W-1:0] KEY_MASK      = 32'h7FFF_FFFF;
    localparam logic [CFG_W-1:0] TABLE_SIZE_RST = 11'd1024;

    typedef enum logic {
        CMD_SEARCH = 1'b0,
        CMD_INSERT = 1'b1
    } lpht_cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_SUCCESS   = 2'd0,
        ST_ABSENT    = 2'd1,
        ST_EXHAUSTED = 2'd2,
        ST_FULL      = 2'd3
    } lpht_status_t;

    typedef enum logic [1:0] {
        FE_IDLE,
        FE_MOD,
        FE_PUSH
    } lpht_fe_state_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_PROBE,
        BK_DONE
    } lpht_bk_state_t;

endpackage

// ===== hdl/lpht_front.sv =====
`timescale 1ns / 1ps
// Front end: takes in a transaction and reduces the masked key modulo the table size.
// Uses lpht_pkg; hands {command, key, home slot} to the job queue.
module lpht_front #(
    parameter int ESZ_W = 11,
    parameter int IDX_W = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [ESZ_W-1:0]              eff_size,
    input  logic                          take_valid,
    output logic                          take_ready,
    input  logic                          take_cmd,
    input  logic [lpht_pkg::KEY_W-1:0]    take_key,
    output logic                          push_valid,
    input  logic                          push_ready,
    output logic [lpht_pkg::KEY_W+IDX_W:0] push_data
);

    localparam int RW = ESZ_W + 1;

    lpht_pkg::lpht_fe_state_t            state_reg, state_next;
    logic [lpht_pkg::MOD_CNT_W-1:0]      mod_cnt_reg, mod_cnt_next;
    logic [RW-1:0]                       rem_reg, rem_next;
    logic [lpht_pkg::KEY_W-1:0]          div_reg, div_next;
    logic                                cmd_reg, cmd_next;
    logic [lpht_pkg::KEY_W-1:0]          key_reg, key_next;
    logic                                accept;

    assign accept = take_valid && take_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lpht_pkg::FE_IDLE:
            begin
                if (accept)
                begin
                    state_next = lpht_pkg::FE_MOD;
                end
            end
            lpht_pkg::FE_MOD:
            begin
                if (mod_cnt_reg == lpht_pkg::MOD_CNT_W'(lpht_pkg::MOD_CYCLES - 1))
                begin
                    state_next = lpht_pkg::FE_PUSH;
                end
            end
            lpht_pkg::FE_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = lpht_pkg::FE_IDLE;
                end
            end
            default:
            begin
                state_next = lpht_pkg::FE_IDLE;
            end
        endcase
    end

    // outputs and datapath: a few restoring remainder steps per cycle
    always_comb
    begin
        logic [RW-1:0]              r;
        logic [lpht_pkg::KEY_W-1:0] d;
        take_ready  = (state_reg == lpht_pkg::FE_IDLE);
        push_valid  = (state_reg == lpht_pkg::FE_PUSH);
        mod_cnt_next = mod_cnt_reg;
        rem_next    = rem_reg;
        div_next    = div_reg;
        cmd_next    = cmd_reg;
        key_next    = key_reg;
        r           = rem_reg;
        d           = div_reg;
        case (state_reg)
            lpht_pkg::FE_IDLE:
            begin
                if (accept)
                begin
                    cmd_next     = take_cmd;
                    key_next     = take_key;
                    div_next     = take_key & lpht_pkg::KEY_MASK;
                    rem_next     = '0;
                    mod_cnt_next = '0;
                end
            end
            lpht_pkg::FE_MOD:
            begin
                for (int k = 0; k < lpht_pkg::MOD_BITS_PER_CYCLE; k++)
                begin
                    r = {r[RW-2:0], d[lpht_pkg::KEY_W-1]};
                    d = {d[lpht_pkg::KEY_W-2:0], 1'b0};
                    if (r >= {1'b0, eff_size})
                    begin
                        r = r - {1'b0, eff_size};
                    end
                end
                rem_next     = r;
                div_next     = d;
                mod_cnt_next = mod_cnt_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign push_data = {cmd_reg, key_reg, IDX_W'(rem_reg)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= lpht_pkg::FE_IDLE;
            mod_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            mod_cnt_reg <= mod_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        cmd_reg <= cmd_next;
        key_reg <= key_next;
    end

    // remainder is reduced below the table size when it is handed on
    a_rem_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lpht_pkg::FE_PUSH) |-> (rem_reg < {1'b0, eff_size}))
        else $error("home slot not below table size");

    a_mod_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (mod_cnt_reg == '0 && rem_reg == '0 && state_reg == lpht_pkg::FE_MOD))
        else $error("reduction did not restart on a new transaction");

    a_push_after_mod: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(push_valid) |-> ($past(state_reg) == lpht_pkg::FE_MOD
                               && $past(mod_cnt_reg)
                                  == lpht_pkg::MOD_CNT_W'(lpht_pkg::MOD_CYCLES - 1)))
        else $error("job offered before the reduction finished");

endmodule

// ===== hdl/lpht_queue.sv =====
`timescale 1ns / 1ps
// Small FIFO between the front end and the probe engine.
// Does not use lpht_pkg; holds opaque job words.
module lpht_queue #(
    parameter int DATA_W = 43,
    parameter int DEPTH  = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic              do_push, do_pop;

    assign push_ready = (fill_reg != CNT_W'(DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = store_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hdl/lpht_back.sv =====
`timescale 1ns / 1ps
// Probe engine: slot memory, clearing sweep after reset, linear probe walk and result register.
// Uses lpht_pkg; fed by lpht_queue.
module lpht_back #(
    parameter int MAX_SLOTS = 1024,
    parameter int ESZ_W     = 11,
    parameter int IDX_W     = 10
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [ESZ_W-1:0]                   eff_size,
    output logic                               clearing,
    input  logic                               job_valid,
    output logic                               job_ready,
    input  logic [lpht_pkg::KEY_W+IDX_W:0]     job_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [lpht_pkg::STATUS_W-1:0]      status,
    output logic [lpht_pkg::SLOT_OUT_W-1:0]    slot_index
);

    localparam int KW    = lpht_pkg::KEY_W;
    localparam int JOB_W = KW + IDX_W + 1;

    // slot word: valid mark on top of the stored key
    logic [KW:0] mem [MAX_SLOTS];
    logic [KW:0] rd_data_reg;

    lpht_pkg::lpht_bk_state_t     state_reg, state_next;
    logic [IDX_W-1:0]             clr_addr_reg, clr_addr_next;
    logic [ESZ_W-1:0]             probe_cnt_reg, probe_cnt_next;
    logic [lpht_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                         out_valid_reg, out_valid_next;
    lpht_pkg::lpht_status_t       out_status_reg, out_status_next;
    logic [IDX_W-1:0]             out_slot_reg, out_slot_next;
    logic                         cmd_reg, cmd_next;
    logic [KW-1:0]                key_reg, key_next;
    logic [IDX_W-1:0]             p_reg, p_next;
    lpht_pkg::lpht_status_t       res_status_reg, res_status_next;
    logic [IDX_W-1:0]             res_slot_reg, res_slot_next;

    logic                         job_cmd;
    logic [KW-1:0]                job_key;
    logic [IDX_W-1:0]             job_home;
    logic                         table_full;
    logic                         slot_empty, key_match, last_probe, probe_done;
    logic [IDX_W-1:0]             p_step;
    logic                         out_free;
    logic                         wr_en;
    logic [IDX_W-1:0]             wr_addr, rd_addr;
    logic [KW:0]                  wr_data;

    assign job_cmd    = job_data[JOB_W-1];
    assign job_key    = job_data[JOB_W-2 -: KW];
    assign job_home   = job_data[IDX_W-1:0];
    assign table_full = (32'(count_reg) >= 32'(eff_size));
    assign slot_empty = !rd_data_reg[KW];
    assign key_match  = (rd_data_reg[KW-1:0] == key_reg);
    assign last_probe = (probe_cnt_reg == eff_size - 1'b1);
    assign probe_done = slot_empty || last_probe
                        || (cmd_reg == lpht_pkg::CMD_SEARCH && key_match);
    assign p_step     = (32'(p_reg) + 1 == 32'(eff_size)) ? '0 : p_reg + 1'b1;
    assign out_free   = !out_valid_reg || out_ready;

    assign clearing   = (state_reg == lpht_pkg::BK_CLEAR);
    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign slot_index = lpht_pkg::SLOT_OUT_W'(out_slot_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lpht_pkg::BK_CLEAR:
            begin
                if (clr_addr_reg == IDX_W'(MAX_SLOTS - 1))
                begin
                    state_next = lpht_pkg::BK_IDLE;
                end
            end
            lpht_pkg::BK_IDLE:
            begin
                if (job_valid)
                begin
                    if (job_cmd == lpht_pkg::CMD_INSERT && table_full)
                    begin
                        state_next = lpht_pkg::BK_DONE;
                    end
                    else
                    begin
                        state_next = lpht_pkg::BK_PROBE;
                    end
                end
            end
            lpht_pkg::BK_PROBE:
            begin
                if (probe_done)
                begin
                    state_next = lpht_pkg::BK_DONE;
                end
            end
            lpht_pkg::BK_DONE:
            begin
                if (out_free)
                begin
                    state_next = lpht_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = lpht_pkg::BK_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        job_ready       = (state_reg == lpht_pkg::BK_IDLE);
        clr_addr_next   = clr_addr_reg;
        probe_cnt_next  = probe_cnt_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        p_next          = p_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        wr_en           = 1'b0;
        wr_addr         = p_reg;
        wr_data         = {1'b1, key_reg};
        // read every cycle: home slot when idle, else the next slot; only used while probing
        rd_addr         = (state_reg == lpht_pkg::BK_IDLE) ? job_home : p_step;
        case (state_reg)
            lpht_pkg::BK_CLEAR:
            begin
                wr_en         = 1'b1;
                wr_addr       = clr_addr_reg;
                wr_data       = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
            end
            lpht_pkg::BK_IDLE:
            begin
                if (job_valid)
                begin
                    cmd_next        = job_cmd;
                    key_next        = job_key;
                    p_next          = job_home;
                    probe_cnt_next  = '0;
                    res_status_next = lpht_pkg::ST_FULL;
                    res_slot_next   = '0;
                end
            end
            lpht_pkg::BK_PROBE:
            begin
                if (!probe_done)
                begin
                    p_next         = p_step;
                    probe_cnt_next = probe_cnt_reg + 1'b1;
                end
                else if (cmd_reg == lpht_pkg::CMD_SEARCH)
                begin
                    if (slot_empty)
                    begin
                        res_status_next = lpht_pkg::ST_ABSENT;
                        res_slot_next   = '0;
                    end
                    else if (key_match)
                    begin
                        res_status_next = lpht_pkg::ST_SUCCESS;
                        res_slot_next   = p_reg;
                    end
                    else
                    begin
                        res_status_next = lpht_pkg::ST_EXHAUSTED;
                        res_slot_next   = '0;
                    end
                end
                else
                begin
                    if (slot_empty)
                    begin
                        wr_en           = 1'b1;
                        count_next      = count_reg + 1'b1;
                        res_status_next = lpht_pkg::ST_SUCCESS;
                        res_slot_next   = p_reg;
                    end
                    else
                    begin
                        res_status_next = lpht_pkg::ST_FULL;
                        res_slot_next   = '0;
                    end
                end
            end
            lpht_pkg::BK_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_slot_next   = res_slot_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lpht_pkg::BK_CLEAR;
            clr_addr_reg  <= '0;
            probe_cnt_reg <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            probe_cnt_reg <= probe_cnt_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        p_reg          <= p_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    a_no_reclear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != lpht_pkg::BK_CLEAR) |=> (state_reg != lpht_pkg::BK_CLEAR))
        else $error("clearing sweep restarted");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + 1'b1 && $past(state_reg) == lpht_pkg::BK_PROBE
             && $past(cmd_reg) == lpht_pkg::CMD_INSERT))
        else $error("entry count moved outside an insert");

    a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lpht_pkg::BK_PROBE) |->
            (32'(probe_cnt_reg) < 32'(eff_size) && 32'(p_reg) < 32'(eff_size)))
        else $error("probe walked past the table size");

    a_fail_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lpht_pkg::BK_DONE && res_status_reg != lpht_pkg::ST_SUCCESS)
            |-> (res_slot_reg == '0))
        else $error("failed transaction carries a slot index");

endmodule

// ===== hdl/linear_probe_hash_table.sv =====
`timescale 1ns / 1ps
// Top level of the linear probing hash table: config register, front end, job queue, probe engine.
// Uses lpht_pkg, lpht_front, lpht_queue and lpht_back.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one transaction: command (search or insert)
//   and a signed 32-bit page_key. Output channel (out_valid/out_ready) returns one result
//   per transaction, in order: status and slot_index (zero unless status is success).
//   Config channel (cfg_valid/cfg_ready) writes table_size; cfg_ready is always high.
//   Write it only while no transaction is in flight.
// Timing:
//   The front end takes a transaction, reduces the masked key modulo the table size
//   (4 remainder bits per cycle) and hands it to the queue once the queue has room; it
//   takes no new transaction before the current one is handed on.
//   The probe engine pops a job, visits the slots of its probe chain one at a time and
//   registers the result; it pops no new job until the result has moved to the output
//   register. Long probe chains make the engine the limit, the queue absorbing short
//   bursts.
// Reset:
//   After rst_n rises the engine sweeps all MAX_SLOTS slots of the slot memory, one slot per
//   cycle; in_ready stays low during the sweep. table_size returns to 1024, count to zero.
// Stall:
//   A held result waits in the output register; the front end keeps taking transactions
//   until the queue fills, then in_ready drops.
module linear_probe_hash_table #(
    parameter int MAX_SLOTS = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lpht_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 command,
    input  logic signed [lpht_pkg::KEY_W-1:0]    page_key,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [lpht_pkg::STATUS_W-1:0]        status,
    output logic [lpht_pkg::SLOT_OUT_W-1:0]      slot_index
);

    localparam int IDX_W   = $clog2(MAX_SLOTS);
    localparam int ESZ_W   = $clog2(MAX_SLOTS + 1);
    localparam int JOB_W   = lpht_pkg::KEY_W + IDX_W + 1;
    localparam int Q_DEPTH = 2;

    logic [lpht_pkg::CFG_W-1:0] table_size_reg, table_size_next;
    logic [ESZ_W-1:0]           eff_size;
    logic                       clearing;
    logic                       fe_ready;
    logic                       push_valid, push_ready;
    logic [JOB_W-1:0]           push_data;
    logic                       job_valid, job_ready;
    logic [JOB_W-1:0]           job_data;

    // config register: always ready, written on each cfg transaction
    assign cfg_ready = 1'b1;

    always_comb
    begin
        table_size_next = table_size_reg;
        if (cfg_valid && cfg_ready)
        begin
            table_size_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= lpht_pkg::TABLE_SIZE_RST;
        end
        else
        begin
            table_size_reg <= table_size_next;
        end
    end

    // effective size: zero acts as one, anything above the memory depth saturates
    always_comb
    begin
        if (table_size_reg == '0)
        begin
            eff_size = ESZ_W'(1);
        end
        else if (32'(table_size_reg) > 32'(MAX_SLOTS))
        begin
            eff_size = ESZ_W'(MAX_SLOTS);
        end
        else
        begin
            eff_size = ESZ_W'(table_size_reg);
        end
    end

    // hold off new transactions during the clearing sweep
    assign in_ready = fe_ready && !clearing;

    lpht_front #(
        .ESZ_W (ESZ_W),
        .IDX_W (IDX_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .eff_size   (eff_size),
        .take_valid (in_valid && !clearing),
        .take_ready (fe_ready),
        .take_cmd   (command),
        .take_key   (page_key),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    lpht_queue #(
        .DATA_W (JOB_W),
        .DEPTH  (Q_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (job_valid),
        .pop_ready  (job_ready),
        .pop_data   (job_data)
    );

    lpht_back #(
        .MAX_SLOTS (MAX_SLOTS),
        .ESZ_W     (ESZ_W),
        .IDX_W     (IDX_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .eff_size   (eff_size),
        .clearing   (clearing),
        .job_valid  (job_valid),
        .job_ready  (job_ready),
        .job_data   (job_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .slot_index (slot_index)
    );

endmodule
